/* rtl/iaa_pkg.sv */
// Shared types and constants of the affine image augmentation block.
`timescale 1ns / 1ps
package iaa_pkg;

    // image side length; the 5-bit position ports are sized for it
    localparam int IMAGE_SIDE = 28;

    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_RECIP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_COS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_SIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_THR   = 3'd5;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam int CFG_DATA_W = 17;

    // configuration register set
    typedef struct packed {
        logic [16:0]        scale_recip;
        logic [14:0]        rot_cos;
        logic signed [14:0] rot_sin;
        logic signed [3:0]  shift_x;
        logic signed [2:0]  shift_y;
        logic [9:0]         noise_threshold;
    } cfg_t;

    // shared multiply-accumulate unit opcodes
    localparam logic [1:0] MAC_LOAD = 2'd0;  // acc = a*b
    localparam logic [1:0] MAC_ADD  = 2'd1;  // acc = acc + a*b
    localparam logic [1:0] MAC_SUB  = 2'd2;  // acc = acc - a*b

    typedef struct packed {
        logic       en;
        logic [1:0] op;
    } mac_ctl_t;

endpackage

/* rtl/iaa_mac.sv */
// Shared signed multiply-accumulate unit, one product per cycle while ctl.en is set.
`timescale 1ns / 1ps
module iaa_mac
    import iaa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  mac_ctl_t           ctl,
    input  logic signed [24:0] a,
    input  logic signed [17:0] b,
    output logic signed [49:0] acc
);

    logic signed [42:0] prod;
    logic signed [49:0] acc_reg;
    logic signed [49:0] acc_next;

    assign prod = a * b;
    assign acc  = acc_reg;

    // select accumulate operation
    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.en)
        begin
            case (ctl.op)
                MAC_LOAD: acc_next = 50'(prod);
                MAC_ADD:  acc_next = acc_reg + 50'(prod);
                MAC_SUB:  acc_next = acc_reg - 50'(prod);
                default:  acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

endmodule

/* rtl/image_affine_augment.sv */
// Top level of the affine image augmentation block: image store, sequencer, shared MAC.
//
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  cmd pos_x pos_y pixel_in noise_draw noise_level
// out      output     out_valid/out_stall pixel_out
// cfg      input      cfg_valid/cfg_ready cfg_index cfg_data
//
// A load writes one pixel of the image store. A full read computes the rotated
// coordinates, then four zoomed samples (coordinates, four memory reads, eight blend
// products each) and the final blend; an outside shift ends the read early.
// Reset clears control and sets configuration to defaults; the image memory is undefined until loaded.
// in_stall stays high while an item is in work or a result waits under out_stall;
// cfg_ready is high only in idle with no item offered.
`timescale 1ns / 1ps
module image_affine_augment
    import iaa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  cmd,
    input  logic [4:0]            pos_x,
    input  logic [4:0]            pos_y,
    input  logic [7:0]            pixel_in,
    input  logic [9:0]            noise_draw,
    input  logic [7:0]            noise_level,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            pixel_out,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH  = IMAGE_SIDE * IMAGE_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CTR    = IMAGE_SIDE / 2;
    localparam int SIDE_Q = IMAGE_SIDE * 65536;
    localparam int CTR_Q  = CTR * 65536;

    // sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_LOAD   = 5'd1;
    localparam logic [4:0] S_RU0    = 5'd2;   // rx*cos
    localparam logic [4:0] S_RU1    = 5'd3;   // - ry*sin
    localparam logic [4:0] S_RV0    = 5'd4;   // rx*sin, latch u
    localparam logic [4:0] S_RV1    = 5'd5;   // + ry*cos
    localparam logic [4:0] S_RCHK   = 5'd6;   // latch v, check
    localparam logic [4:0] S_ZU     = 5'd7;   // (a-C)*scale
    localparam logic [4:0] S_ZV     = 5'd8;   // latch zu, (b-C)*scale
    localparam logic [4:0] S_ZCHK   = 5'd9;   // latch zv, check
    localparam logic [4:0] S_MRD    = 5'd10;  // issue memory read
    localparam logic [4:0] S_MWT    = 5'd11;  // capture read data
    localparam logic [4:0] S_BL     = 5'd12;  // blend products
    localparam logic [4:0] S_BLW    = 5'd13;  // blend result
    localparam logic [4:0] S_NXT    = 5'd14;  // next rotated corner
    localparam logic [4:0] S_FB     = 5'd15;  // final blend products
    localparam logic [4:0] S_FBW    = 5'd16;
    localparam logic [4:0] S_DONE   = 5'd17;
    localparam logic [4:0] S_OUT    = 5'd18;

    logic [4:0] state_reg, state_next;
    cfg_t cfg_reg;

    // memory
    logic [7:0]        mem [DEPTH];
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_rd;

    // item registers
    logic [4:0] px_reg, py_reg;
    logic [7:0] pix_reg, lvl_reg;
    logic       noise_reg;
    logic [7:0] out_reg;

    // rotation sample
    logic signed [49:0] ru_reg;
    logic [4:0]  rx0_reg, ry0_reg;
    logic [15:0] rfx_reg, rfy_reg;
    logic [1:0]  rc_reg;       // rotated corner index
    logic [7:0]  zval_reg [4]; // zoomed corner values
    // zoom sample
    logic [4:0]  zx0_reg, zy0_reg;
    logic [15:0] zfx_reg;
    logic [15:0] coord_frac_y_reg;
    logic [1:0]  mc_reg;       // source corner index
    logic [7:0]  sval_reg [4];
    logic [2:0]  bstep_reg;    // blend product counter
    logic [41:0] top_reg, bot_reg;

    // shared MAC
    mac_ctl_t           mctl;
    logic signed [24:0] ma;
    logic signed [17:0] mb;
    logic signed [49:0] acc;

    iaa_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mctl),
        .a     (ma),
        .b     (mb),
        .acc   (acc)
    );

    logic signed [6:0] xs, ys;
    logic signed [6:0] rx, ry, za, zb;
    logic [4:0] rc_x, rc_y;
    logic signed [49:0] coord;
    logic coord_ok, v_ok;

    assign xs = 7'(signed'({2'b00, px_reg})) + 7'(cfg_reg.shift_x);
    assign ys = 7'(signed'({2'b00, py_reg})) + 7'(cfg_reg.shift_y);
    assign rx = xs - 7'(CTR);
    assign ry = ys - 7'(CTR);

    // rotated corner position, clamped at the last row and column
    always_comb
    begin
        rc_x = rx0_reg;
        rc_y = ry0_reg;
        if (rc_reg[0] && (32'(rx0_reg) + 1 < IMAGE_SIDE))
            rc_x = rx0_reg + 5'd1;
        if (rc_reg[1] && (32'(ry0_reg) + 1 < IMAGE_SIDE))
            rc_y = ry0_reg + 5'd1;
    end
    assign za = 7'(signed'({2'b00, rc_x})) - 7'(CTR);
    assign zb = 7'(signed'({2'b00, rc_y})) - 7'(CTR);

    // coordinate offset and range check on the accumulator
    always_comb
    begin
        if (state_reg == S_RV0 || state_reg == S_RCHK)
            coord = 50'(CTR_Q) + (acc <<< 2);
        else
            coord = 50'(CTR_Q) + acc;
    end
    assign coord_ok = (coord >= 0) && (coord < 50'(SIDE_Q));
    assign v_ok     = coord_ok;

    // source corner address
    logic [4:0] sx, sy;
    always_comb
    begin
        sx = zx0_reg;
        sy = zy0_reg;
        if (mc_reg[0] && (32'(zx0_reg) + 1 < IMAGE_SIDE))
            sx = zx0_reg + 5'd1;
        if (mc_reg[1] && (32'(zy0_reg) + 1 < IMAGE_SIDE))
            sy = zy0_reg + 5'd1;
    end
    assign rd_addr = ADDR_W'(32'(sy) * IMAGE_SIDE + 32'(sx));

    // blend operand selection: steps 0..7 are top, bottom and final rows
    logic [15:0] bfx, bfy;
    logic [7:0]  v0, v1, v2, v3;
    logic        final_bl;
    assign final_bl = (state_reg == S_FB) || (state_reg == S_FBW);
    assign bfx = final_bl ? rfx_reg : zfx_reg;
    assign bfy = final_bl ? rfy_reg : 16'(coord_frac_y_reg);
    assign v0  = final_bl ? zval_reg[0] : sval_reg[0];
    assign v1  = final_bl ? zval_reg[1] : sval_reg[1];
    assign v2  = final_bl ? zval_reg[2] : sval_reg[2];
    assign v3  = final_bl ? zval_reg[3] : sval_reg[3];

    logic [16:0] wx0, wx1, wy0, wy1;
    assign wx0 = 17'd65536 - 17'(bfx);
    assign wx1 = 17'(bfx);
    assign wy0 = 17'd65536 - 17'(bfy);
    assign wy1 = 17'(bfy);

    // MAC operand schedule
    always_comb
    begin
        mctl = '{en: 1'b0, op: MAC_LOAD};
        ma   = '0;
        mb   = '0;
        unique case (state_reg)
            S_RU0:
            begin
                mctl = '{en: 1'b1, op: MAC_LOAD};
                ma = 25'(rx);
                mb = 18'(signed'({1'b0, cfg_reg.rot_cos}));
            end
            S_RU1:
            begin
                mctl = '{en: 1'b1, op: MAC_SUB};
                ma = 25'(ry);
                mb = 18'(cfg_reg.rot_sin);
            end
            S_RV0:
            begin
                mctl = '{en: 1'b1, op: MAC_LOAD};
                ma = 25'(rx);
                mb = 18'(cfg_reg.rot_sin);
            end
            S_RV1:
            begin
                mctl = '{en: 1'b1, op: MAC_ADD};
                ma = 25'(ry);
                mb = 18'(signed'({1'b0, cfg_reg.rot_cos}));
            end
            S_ZU:
            begin
                mctl = '{en: 1'b1, op: MAC_LOAD};
                ma = 25'(za);
                mb = 18'(signed'({1'b0, cfg_reg.scale_recip}));
            end
            S_ZV:
            begin
                mctl = '{en: 1'b1, op: MAC_LOAD};
                ma = 25'(zb);
                mb = 18'(signed'({1'b0, cfg_reg.scale_recip}));
            end
            S_BL, S_FB:
            begin
                mctl.en = 1'b1;
                case (bstep_reg)
                    3'd0: begin mctl.op = MAC_LOAD; ma = 25'(v0); mb = 18'(wx0); end
                    3'd1: begin mctl.op = MAC_ADD;  ma = 25'(v1); mb = 18'(wx1); end
                    3'd2: begin mctl.op = MAC_LOAD; ma = 25'(v2); mb = 18'(wx0); end
                    3'd3: begin mctl.op = MAC_ADD;  ma = 25'(v3); mb = 18'(wx1); end
                    // row sums are at most 24 bits, split in two 21-bit halves
                    3'd4: begin mctl.op = MAC_LOAD; ma = 25'(top_reg[41:21]);
                                mb = 18'(wy0); end
                    3'd5: begin mctl.op = MAC_ADD;  ma = 25'(bot_reg[41:21]);
                                mb = 18'(wy1); end
                    3'd6: begin mctl.op = MAC_LOAD; ma = 25'(top_reg[20:0]);
                                mb = 18'(wy0); end
                    default: begin mctl.op = MAC_ADD; ma = 25'(bot_reg[20:0]);
                                mb = 18'(wy1); end
                endcase
            end
            default: ;
        endcase
    end

    // high-half partial sum, combined with the low half at the end
    logic [49:0] hi_reg;
    logic [49:0] blend_sum;
    assign blend_sum = (hi_reg << 21) + 50'(acc);

    assign cfg_ready = (state_reg == S_IDLE) && !in_valid;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign pixel_out = out_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = (cmd == CMD_READ) ? S_RU0 : S_LOAD;
            S_LOAD: state_next = S_IDLE;
            S_RU0:
                if (xs < 0 || xs >= 7'(IMAGE_SIDE) || ys < 0 || ys >= 7'(IMAGE_SIDE))
                    state_next = S_DONE;
                else
                    state_next = S_RU1;
            S_RU1:  state_next = S_RV0;
            S_RV0:  state_next = coord_ok ? S_RV1 : S_DONE;
            S_RV1:  state_next = S_RCHK;
            S_RCHK: state_next = v_ok ? S_ZU : S_DONE;
            S_ZU:   state_next = S_ZV;
            S_ZV:   state_next = coord_ok ? S_ZCHK : S_NXT;
            S_ZCHK: state_next = coord_ok ? S_MRD : S_NXT;
            S_MRD:  state_next = S_MWT;
            S_MWT:  state_next = (mc_reg == 2'd3) ? S_BL : S_MRD;
            S_BL:   state_next = (bstep_reg == 3'd7) ? S_BLW : S_BL;
            S_BLW:  state_next = S_NXT;
            S_NXT:  state_next = (rc_reg == 2'd3) ? S_FB : S_ZU;
            S_FB:   state_next = (bstep_reg == 3'd7) ? S_FBW : S_FB;
            S_FBW:  state_next = S_DONE;
            S_DONE: state_next = S_OUT;
            S_OUT:  if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cfg_reg   <= '{scale_recip: 17'd65536, rot_cos: 15'd16384, rot_sin: '0,
                           shift_x: '0, shift_y: '0, noise_threshold: '0};
            rc_reg    <= '0;
            mc_reg    <= '0;
            bstep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_SCALE_RECIP: cfg_reg.scale_recip     <= cfg_data[16:0];
                    REG_ROT_COS:     cfg_reg.rot_cos         <= cfg_data[14:0];
                    REG_ROT_SIN:     cfg_reg.rot_sin         <= cfg_data[14:0];
                    REG_SHIFT_X:     cfg_reg.shift_x         <= cfg_data[3:0];
                    REG_SHIFT_Y:     cfg_reg.shift_y         <= cfg_data[2:0];
                    REG_NOISE_THR:   cfg_reg.noise_threshold <= cfg_data[9:0];
                    default: ;
                endcase
            end
            // advance corner and step counters
            if (state_reg == S_RCHK)
                rc_reg <= '0;
            else if (state_reg == S_NXT)
                rc_reg <= rc_reg + 2'd1;
            if (state_reg == S_ZCHK)
                mc_reg <= '0;
            else if (state_reg == S_MWT)
                mc_reg <= mc_reg + 2'd1;
            if (state_reg == S_BL || state_reg == S_FB)
                bstep_reg <= bstep_reg + 3'd1;
            else
                bstep_reg <= '0;
        end
    end

    // image memory: one write or one read per cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD && px_reg < 5'(IMAGE_SIDE) && py_reg < 5'(IMAGE_SIDE))
            mem[ADDR_W'(32'(py_reg) * IMAGE_SIDE + 32'(px_reg))] <= pix_reg;
        if (mem_rd)
            rd_data_reg <= mem[rd_addr];
    end
    assign mem_rd = (state_reg == S_MRD);

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            px_reg    <= pos_x;
            py_reg    <= pos_y;
            pix_reg   <= pixel_in;
            lvl_reg   <= noise_level;
            noise_reg <= (noise_draw < cfg_reg.noise_threshold);
            out_reg   <= '0;
        end
        if (state_reg == S_RV0)
            ru_reg <= coord;
        if (state_reg == S_RCHK)
        begin
            rx0_reg <= 5'(ru_reg[49:16]);
            rfx_reg <= ru_reg[15:0];
            ry0_reg <= 5'(coord[49:16]);
            rfy_reg <= coord[15:0];
        end
        if (state_reg == S_ZV)
        begin
            zx0_reg <= 5'(coord[49:16]);
            zfx_reg <= coord[15:0];
        end
        if (state_reg == S_ZCHK)
        begin
            zy0_reg          <= 5'(coord[49:16]);
            coord_frac_y_reg <= coord[15:0];
        end
        // zoomed value defaults to zero when its source point falls outside
        if (state_reg == S_ZU)
            zval_reg[rc_reg] <= '0;
        if (state_reg == S_MWT)
            sval_reg[mc_reg] <= rd_data_reg;
        if (state_reg == S_BL || state_reg == S_FB)
        begin
            if (bstep_reg == 3'd2)
                top_reg <= 42'(acc);
            if (bstep_reg == 3'd4)
                bot_reg <= 42'(acc);
            if (bstep_reg == 3'd6)
                hi_reg <= acc;
        end
        if (state_reg == S_BLW)
            zval_reg[rc_reg] <= blend_sum[39:32];
        if (state_reg == S_FBW)
            out_reg <= blend_sum[39:32];
        if (state_reg == S_DONE && noise_reg)
            out_reg <= lvl_reg;
    end

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the affine image augmentation block.
`timescale 1ns / 1ps
module tb;
    import iaa_pkg::*;

    localparam int SIDE       = IMAGE_SIDE;
    localparam int CTR        = SIDE / 2;
    localparam longint ONE    = 65536;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 250;

    // register indexes outside the defined set
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  cmd;
    logic [4:0]            pos_x;
    logic [4:0]            pos_y;
    logic [7:0]            pixel_in;
    logic [9:0]            noise_draw;
    logic [7:0]            noise_level;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            pixel_out;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state
    logic [7:0] img_mem [0:SIDE*SIDE-1];
    longint     cfg_scale, cfg_cos, cfg_sin, cfg_sx, cfg_sy, cfg_thr;
    logic [7:0] expected_pixels [$];

    int  error_count;
    int  idle_cycles;
    bit  quiet;
    int  stall_left;

    image_affine_augment u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pixel_in    (pixel_in),
        .noise_draw  (noise_draw),
        .noise_level (noise_level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_out   (pixel_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Pick an idle length: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(15, 60);
    endfunction

    function automatic bit coord_ok(longint c);
        return c >= 0 && c < SIDE * ONE;
    endfunction

    // Bilinear blend with one truncation at the end.
    function automatic longint mix4(longint a, longint b, longint c, longint d,
                                    longint fx, longint fy);
        longint top;
        longint bot;
        top = (ONE - fx) * a + fx * b;
        bot = (ONE - fx) * c + fx * d;
        return (((ONE - fy) * top) + fy * bot) >>> 32;
    endfunction

    function automatic longint src_at(longint x, longint y);
        return longint'(img_mem[y * SIDE + x]);
    endfunction

    // Sample the zoomed image at an integer point.
    function automatic longint zoom_sample(longint a, longint b);
        longint u, v, x0, y0, x1, y1;
        u = CTR * ONE + (a - CTR) * cfg_scale;
        v = CTR * ONE + (b - CTR) * cfg_scale;
        if (!coord_ok(u) || !coord_ok(v))
            return 0;
        x0 = u >>> 16;
        y0 = v >>> 16;
        x1 = (x0 + 1 < SIDE) ? x0 + 1 : SIDE - 1;
        y1 = (y0 + 1 < SIDE) ? y0 + 1 : SIDE - 1;
        return mix4(src_at(x0, y0), src_at(x1, y0), src_at(x0, y1), src_at(x1, y1),
                    u & 16'hFFFF, v & 16'hFFFF);
    endfunction

    // Sample the rotated image, which samples the zoomed one.
    function automatic longint rot_sample(longint p, longint q);
        longint rx, ry, u, v, x0, y0, x1, y1;
        rx = p - CTR;
        ry = q - CTR;
        u = CTR * ONE + 4 * (rx * cfg_cos - ry * cfg_sin);
        v = CTR * ONE + 4 * (rx * cfg_sin + ry * cfg_cos);
        if (!coord_ok(u) || !coord_ok(v))
            return 0;
        x0 = u >>> 16;
        y0 = v >>> 16;
        x1 = (x0 + 1 < SIDE) ? x0 + 1 : SIDE - 1;
        y1 = (y0 + 1 < SIDE) ? y0 + 1 : SIDE - 1;
        return mix4(zoom_sample(x0, y0), zoom_sample(x1, y0),
                    zoom_sample(x0, y1), zoom_sample(x1, y1),
                    u & 16'hFFFF, v & 16'hFFFF);
    endfunction

    // Update the predictor for one accepted item.
    function automatic void predict_item(logic c, logic [4:0] px, logic [4:0] py,
                                         logic [7:0] pix, logic [9:0] draw,
                                         logic [7:0] level);
        longint xs, ys, val;
        if (c == CMD_LOAD)
        begin
            if (px < SIDE && py < SIDE)
                img_mem[py * SIDE + px] = pix;
            return;
        end
        xs = longint'(px) + cfg_sx;
        ys = longint'(py) + cfg_sy;
        val = 0;
        if (xs >= 0 && xs < SIDE && ys >= 0 && ys < SIDE)
            val = rot_sample(xs, ys);
        if (longint'(draw) < cfg_thr)
            val = longint'(level);
        expected_pixels.insert(expected_pixels.size(), val[7:0]);
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx,
                                      logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SCALE_RECIP: cfg_scale = longint'(data);
            REG_ROT_COS:     cfg_cos   = longint'(data[14:0]);
            REG_ROT_SIN:     cfg_sin   = longint'($signed(data[14:0]));
            REG_SHIFT_X:     cfg_sx    = longint'($signed(data[3:0]));
            REG_SHIFT_Y:     cfg_sy    = longint'($signed(data[2:0]));
            REG_NOISE_THR:   cfg_thr   = longint'(data[9:0]);
            default: ;
        endcase
    endfunction

    // Send one item, holding it until accepted; valid stays high when no gap follows.
    task automatic send_item(logic c, logic [4:0] px, logic [4:0] py, logic [7:0] pix,
                             logic [9:0] draw, logic [7:0] level);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        pos_x       <= px;
        pos_y       <= py;
        pixel_in    <= pix;
        noise_draw  <= draw;
        noise_level <= level;
        do @(posedge clk); while (in_stall);
        predict_item(c, px, py, pix, draw, level);
    endtask

    task automatic send_read(int px, int py, int draw, int level);
        send_item(CMD_READ, px[4:0], py[4:0], 8'd0, draw[9:0], level[7:0]);
    endtask

    task automatic send_random_read();
        send_read($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                  $urandom_range(0, 1000), $urandom_range(0, 255));
    endtask

    // Lower valid and hold until every expected pixel is back and the block is quiet.
    task automatic drain();
        @(posedge clk);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, value[CFG_DATA_W-1:0]);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(int sc, int co, int si, int sx, int sy, int thr);
        write_reg(REG_SCALE_RECIP, sc);
        write_reg(REG_ROT_COS, co);
        write_reg(REG_ROT_SIN, si);
        write_reg(REG_SHIFT_X, sx);
        write_reg(REG_SHIFT_Y, sy);
        write_reg(REG_NOISE_THR, thr);
    endtask

    task automatic write_random_cfg(int thr);
        write_all($urandom_range(56988, 87382), $urandom_range(14189, 16384),
                  int'($urandom_range(0, 16384)) - 8192,
                  int'($urandom_range(0, 10)) - 5, int'($urandom_range(0, 6)) - 3, thr);
    endtask

    // Fill the whole image so no read ever touches an unwritten pixel.
    task automatic test_load_image();
        int x, y, v;
        for (y = 0; y < SIDE; y++)
            for (x = 0; x < SIDE; x++)
            begin
                v = (x == 0 && y == 0) ? 0 : (x == SIDE - 1 && y == 0) ? 255 :
                    $urandom_range(0, 255);
                send_item(CMD_LOAD, x[4:0], y[4:0], v[7:0], 10'($urandom_range(0, 1000)),
                          8'($urandom));
            end
        drain();
    endtask

    // Corners, centre, last row and column, noise edges, ignored loads.
    task automatic test_directed();
        write_reg(REG_SPARE_LO, 17'h1FFFF);
        write_reg(REG_SPARE_HI, 0);
        send_read(0, 0, 1000, 255);
        send_read(27, 27, 1000, 0);
        send_read(27, 0, 0, 0);
        send_read(0, 27, 512, 0);
        send_read(14, 14, 1000, 0);
        send_read(27, 13, 1000, 0);
        send_read(13, 27, 1000, 0);
        send_item(CMD_LOAD, 5'd31, 5'd3, 8'hAA, 10'd0, 8'd0);
        send_item(CMD_LOAD, 5'd2, 5'd28, 8'h55, 10'd0, 8'd0);
        send_item(CMD_LOAD, 5'd31, 5'd31, 8'hFF, 10'd0, 8'd0);
        send_read(2, 3, 1000, 0);
        drain();
        write_all(56988, 14189, -8192, -5, -3, 1);
        send_read(0, 0, 0, 170);
        send_read(1, 1, 1, 85);
        send_read(27, 27, 1000, 0);
        send_read(4, 2, 1000, 0);
        send_read(14, 14, 1000, 0);
        drain();
        write_all(87382, 16384, 8192, 5, 3, 1001);
        send_read(27, 27, 1000, 255);
        send_read(0, 0, 1000, 1);
        send_read(14, 14, 511, 128);
        drain();
        write_all(87382, 16384, 8192, 5, 3, 0);
        send_read(22, 24, 0, 255);
        send_read(0, 0, 1000, 0);
        send_read(14, 14, 1000, 0);
        drain();
    endtask

    // Several register settings, each with a burst of reads.
    task automatic test_config_sweep();
        int k, n;
        for (k = 0; k < 8; k++)
        begin
            write_random_cfg((k == 3) ? 1001 : $urandom_range(0, 120));
            quiet = (k == 5);
            for (n = 0; n < 20; n++)
                send_random_read();
            drain();
        end
        quiet = 1'b0;
    endtask

    // Loads and reads mixed, one burst sent only after a full drain.
    task automatic test_random_mix();
        int n;
        write_random_cfg(80);
        for (n = 0; n < 250; n++)
        begin
            if ($urandom_range(0, 99) < 35)
                send_item(CMD_LOAD, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                          8'($urandom), 10'($urandom_range(0, 1000)), 8'($urandom));
            else
                send_random_read();
            if (n == 120)
                drain();
        end
        drain();
    endtask

    // Result side: random stall and in-order compare.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected pixel_out %0d", $realtime, pixel_out);
                    error_count++;
                end
                else
                begin
                    if (pixel_out !== expected_pixels[0])
                    begin
                        $display("%0t: pixel_out expected %0d actual %0d", $realtime,
                                 expected_pixels[0], pixel_out);
                        error_count++;
                    end
                    void'(expected_pixels.pop_front());
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end
            else
            begin
                stall_left <= pick_gap();
                out_stall  <= 1'b0;
            end
        end
    end

    // Watchdog on cycles with no handshake at all.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        in_valid    = 1'b0;
        cmd         = CMD_LOAD;
        pos_x       = '0;
        pos_y       = '0;
        pixel_in    = '0;
        noise_draw  = '0;
        noise_level = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        error_count = 0;
        idle_cycles = 0;
        quiet       = 1'b0;
        cfg_scale = 65536;
        cfg_cos   = 16384;
        cfg_sin   = 0;
        cfg_sx    = 0;
        cfg_sy    = 0;
        cfg_thr   = 0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_load_image();
        test_directed();
        test_config_sweep();
        test_random_mix();

        repeat (SETTLE) @(posedge clk);
        if (error_count == 0 && expected_pixels.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
